// ----- rtl/mcbt_pkg.sv -----
`timescale 1ns / 1ps

package mcbt_pkg;

	localparam int PIN_W           = 6;
	localparam int REQ_TIME_W      = 16;
	localparam int DEF_TABLE_DEPTH = 8;
	localparam int DEF_TIME_BITS   = 16;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_ADD    = 2'd1,
		OP_UPDATE = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_REPLY
	} state_t;

	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_CHANGE = 1'b1;

	typedef struct packed {
		op_t                   opcode;
		logic [PIN_W-1:0]      pin_number;
		logic                  start_level;
		logic [REQ_TIME_W-1:0] on_time_ms;
		logic [REQ_TIME_W-1:0] off_time_ms;
	} req_t;

	typedef struct packed {
		logic             item_kind;
		logic [PIN_W-1:0] changed_pin;
		logic             new_level;
		logic             success;
		logic             last_item;
	} rsp_t;

	// status of the entry under evaluation
	typedef struct packed {
		logic pin_match;
		logic flip;
	} eval_flags_t;

endpackage

// ----- rtl/multi_channel_blink_timer.sv -----
`timescale 1ns / 1ps

// Channel    Handshake              Payload
// request    req_valid/req_ready    req (mcbt_pkg::req_t)
// result     rsp_valid/rsp_ready    rsp (mcbt_pkg::rsp_t)
//
// Add, or any request on an empty table: the reply state loads the reply into the result register.
// Tick, update, delete: one entry per cycle through the shared evaluate unit, except while
// the result register holds back a pin change; the walk state reads each entry, then the
// reply state loads the reply into the result register. req_ready is high only while idle.
// Reset clears the sequencer, entry count and result valid; table RAM is left as it is
// and only entries below the count are read.

module multi_channel_blink_timer #(
	parameter int TABLE_DEPTH = mcbt_pkg::DEF_TABLE_DEPTH,
	parameter int TIME_BITS   = mcbt_pkg::DEF_TIME_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mcbt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mcbt_pkg::rsp_t rsp
);

	import mcbt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = PIN_W + 1 + 3 * TIME_BITS;

	// entry layout: pin, level, on time, off time, elapsed
	localparam int EL_LO  = 0;
	localparam int OFF_LO = TIME_BITS;
	localparam int ON_LO  = 2 * TIME_BITS;
	localparam int LVL_B  = 3 * TIME_BITS;
	localparam int PIN_LO = 3 * TIME_BITS + 1;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [CW-1:0]        DEPTH_C  = CW'(TABLE_DEPTH);

	// sequencer state
	state_t         state_q, state_d;
	req_t           req_q, req_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic [CW-1:0]  keep_q, keep_d;
	logic [CW-1:0]  count_q, count_d;
	logic           ok_q, ok_d;

	// result register
	rsp_t           rsp_q, emit_data;
	logic           rsp_valid_q, emit, out_free;

	// table RAM ports
	logic           wr_en, rd_en;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [EW-1:0]  wr_data, rd_data;

	// request times clamped to the stored width
	logic [TIME_BITS-1:0] on_c, off_c;

	eval_flags_t          flags;
	logic [TIME_BITS-1:0] elapsed_next;
	logic [PIN_W-1:0]     e_pin;
	logic                 e_level;
	logic                 is_last;

	mcbt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign e_pin   = rd_data[PIN_LO +: PIN_W];
	assign e_level = rd_data[LVL_B];

	mcbt_alu #(
		.TIME_BITS (TIME_BITS)
	) u_alu (
		.entry_pin     (e_pin),
		.entry_level   (e_level),
		.entry_on      (rd_data[ON_LO +: TIME_BITS]),
		.entry_off     (rd_data[OFF_LO +: TIME_BITS]),
		.entry_elapsed (rd_data[EL_LO +: TIME_BITS]),
		.req_pin       (req_q.pin_number),
		.flags         (flags),
		.elapsed_next  (elapsed_next)
	);

	// saturate request times that exceed the stored width
	always_comb begin
		on_c  = ({1'b0, 32'(req_q.on_time_ms)} > {1'b0, 32'(TIME_MAX)})
		        ? TIME_MAX : TIME_BITS'(32'(req_q.on_time_ms));
		off_c = ({1'b0, 32'(req_q.off_time_ms)} > {1'b0, 32'(TIME_MAX)})
		        ? TIME_MAX : TIME_BITS'(32'(req_q.off_time_ms));
	end

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_last   = ((CW'(idx_q) + CW'(1)) == count_q);
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state and datapath controls
	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		idx_d     = idx_q;
		keep_d    = keep_q;
		count_d   = count_q;
		ok_d      = ok_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rd_data;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		emit      = 1'b0;
		emit_data = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_d  = req;
					idx_d  = '0;
					keep_d = '0;
					ok_d   = 1'b0;
					unique case (req.opcode)
						OP_ADD: begin
							// add writes straight from the request, clamped here
							if (count_q < DEPTH_C) begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = {req.pin_number, req.start_level,
								           ((32'(req.on_time_ms) > 32'(TIME_MAX))
								            ? TIME_MAX : TIME_BITS'(32'(req.on_time_ms))),
								           ((32'(req.off_time_ms) > 32'(TIME_MAX))
								            ? TIME_MAX : TIME_BITS'(32'(req.off_time_ms))),
								           {TIME_BITS{1'b0}}};
								count_d = count_q + CW'(1);
								ok_d    = 1'b1;
							end
							state_d = ST_REPLY;
						end
						OP_TICK, OP_UPDATE, OP_DELETE: begin
							if (count_q == '0) begin
								state_d = ST_REPLY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = ST_WALK;
							end
						end
					endcase
				end
			end

			ST_WALK: begin
				// hold the entry while a pin change cannot be placed
				if (!(req_q.opcode == OP_TICK && flags.flip) || out_free) begin
					unique case (req_q.opcode)
						OP_TICK: begin
							wr_en   = 1'b1;
							wr_addr = idx_q;
							wr_data = {e_pin, e_level ^ flags.flip,
							           rd_data[ON_LO +: TIME_BITS],
							           rd_data[OFF_LO +: TIME_BITS],
							           flags.flip ? {TIME_BITS{1'b0}} : elapsed_next};
							if (flags.flip) begin
								emit      = 1'b1;
								emit_data = '{item_kind:   KIND_CHANGE,
								              changed_pin: e_pin,
								              new_level:   ~e_level,
								              success:     1'b1,
								              last_item:   1'b0};
							end
						end
						OP_UPDATE: begin
							if (flags.pin_match) begin
								wr_en   = 1'b1;
								wr_addr = idx_q;
								wr_data = {req_q.pin_number, req_q.start_level,
								           on_c, off_c, {TIME_BITS{1'b0}}};
								ok_d    = 1'b1;
							end
						end
						OP_DELETE: begin
							// drop matches, compact survivors toward the front
							if (flags.pin_match) begin
								ok_d = 1'b1;
							end else begin
								if (keep_q != CW'(idx_q)) begin
									wr_en   = 1'b1;
									wr_addr = keep_q[AW-1:0];
									wr_data = rd_data;
								end
								keep_d = keep_q + CW'(1);
							end
						end
						OP_ADD: begin
						end
					endcase

					if (is_last) begin
						if (req_q.opcode == OP_DELETE) begin
							count_d = keep_d;
						end
						state_d = ST_REPLY;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
						idx_d   = idx_q + AW'(1);
					end
				end
			end

			ST_REPLY: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_data = '{item_kind:   KIND_REPLY,
					              changed_pin: '0,
					              new_level:   1'b0,
					              success:     (req_q.opcode == OP_TICK) ? 1'b1 : ok_q,
					              last_item:   1'b1};
					state_d   = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			keep_q      <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			idx_q   <= idx_d;
			keep_q  <= keep_d;
			ok_q    <= ok_d;
			// load a new result, or drop the one just taken
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		if (emit) begin
			rsp_q <= emit_data;
		end
	end

endmodule

// ----- rtl/mcbt_ram.sv -----
`timescale 1ns / 1ps

module mcbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/mcbt_alu.sv -----
`timescale 1ns / 1ps

module mcbt_alu #(
	parameter int TIME_BITS = mcbt_pkg::DEF_TIME_BITS
) (
	input  logic [mcbt_pkg::PIN_W-1:0] entry_pin,
	input  logic                       entry_level,
	input  logic [TIME_BITS-1:0]       entry_on,
	input  logic [TIME_BITS-1:0]       entry_off,
	input  logic [TIME_BITS-1:0]       entry_elapsed,
	input  logic [mcbt_pkg::PIN_W-1:0] req_pin,
	output mcbt_pkg::eval_flags_t      flags,
	output logic [TIME_BITS-1:0]       elapsed_next
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [TIME_BITS-1:0] limit;

	// saturating increment, then compare against the limit for the current level
	always_comb begin
		elapsed_next    = (entry_elapsed == TIME_MAX) ? TIME_MAX
		                                              : entry_elapsed + TIME_BITS'(1);
		limit           = entry_level ? entry_on : entry_off;
		flags.flip      = (elapsed_next >= limit);
		flags.pin_match = (entry_pin == req_pin);
	end

endmodule
